[hw/rtl/fourier_radial_band_filter_assert.svh]
// Assertion macros for the radial band filter.
`ifndef FOURIER_RADIAL_BAND_FILTER_ASSERT_SVH
`define FOURIER_RADIAL_BAND_FILTER_ASSERT_SVH

// Condition must never hold outside reset.
`define FRBF_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define FRBF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[hw/rtl/frbf_pkg.sv]
`default_nettype none
package frbf_pkg;

  localparam int MAX_DIM   = 512;
  localparam int POS_W     = 9;
  localparam int DIM_W     = 10;
  localparam int DATA_W    = 32;
  localparam int GAIN_W    = 16;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_NUM_W = 50;
  localparam int DIV_DEN_W = 20;
  localparam int DIV_CNT_W = 6;
  localparam int SUM_W     = 50;
  localparam int ROOT_W    = 25;
  localparam int SQ_REM_W  = 26;
  localparam int SQ_CNT_W  = 5;
  localparam int F_W       = 26;

  localparam logic [GAIN_W:0] ONE_Q  = 17'd32768;
  localparam logic [16:0]     COEF_A = 17'd102944;
  localparam logic [15:0]     COEF_B = 16'd42047;
  localparam logic [12:0]     COEF_C = 13'd4639;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HP_CUTOFF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HP_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LP_CUTOFF = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LP_WIDTH  = 3'd7;

  localparam logic [MODE_W-1:0] MODE_MASK_ONLY = 3'd3;

  typedef enum logic [1:0] {
    KIND_LP,
    KIND_HP,
    KIND_BP
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TERM_GO,
    ST_TERM_WAIT,
    ST_SQRT,
    ST_SQRT_FIX,
    ST_EDGE,
    ST_HANN_WAIT,
    ST_HANN_V2,
    ST_HANN_T1,
    ST_HANN_T2,
    ST_HANN_S,
    ST_MASK,
    ST_SCALE_RE,
    ST_SCALE_IM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DIM_W-1:0]  size_x;
    logic [DIM_W-1:0]  size_y;
    logic [DIM_W-1:0]  size_z;
    logic [15:0]       hp_cutoff;
    logic [15:0]       hp_width;
    logic [15:0]       lp_cutoff;
    logic [15:0]       lp_width;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]         ax;
    logic [POS_W-1:0]         ay;
    logic [POS_W-1:0]         az;
    logic [DIM_W-1:0]         dx;
    logic [DIM_W-1:0]         dy;
    logic [DIM_W-1:0]         dz;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic                     last;
  } job_t;

  function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] s);
    logic [DIM_W-1:0] r;
    if (s == '0) begin
      r = DIM_W'(1);
    end else if (s > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = s;
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] fold_index(input logic [POS_W-1:0] idx,
                                                  input logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0] half1;
    logic [DIM_W-1:0] diff;
    half1 = {1'b0, dim[DIM_W-1:1]} + DIM_W'(1);
    diff  = {1'b0, idx};
    if ({1'b0, idx} >= half1) begin
      if ({1'b0, idx} >= dim) begin
        diff = {1'b0, idx} - dim;
      end else begin
        diff = dim - {1'b0, idx};
      end
    end
    return diff[POS_W-1:0];
  endfunction

  function automatic kind_t filter_kind(input logic [MODE_W-1:0] mode);
    kind_t k;
    case (mode)
      3'd0, 3'd3: k = KIND_LP;
      3'd1, 3'd4: k = KIND_HP;
      default:    k = KIND_BP;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/fourier_radial_band_filter.sv]
// Channel   Handshake               Payload
// input     push / full             sample_re, sample_im, first_of_volume
// result    empty / pop             result_re, result_im, mask_value, last_of_volume
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each item runs through the shared radix-2 divider (50 steps per use, three radial
// terms and one per soft edge) and the 25-step square root; bandpass with both edges
// in roll-off divides once for each edge.
// Reset is synchronous; it clears counters, queue, sequencer and the result valid flag.
// The front keeps accepting into a small queue, until it is full, while the back works or its result waits.
`default_nettype none
module fourier_radial_band_filter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [frbf_pkg::DATA_W-1:0]  sample_re,
  input  logic signed [frbf_pkg::DATA_W-1:0]  sample_im,
  input  logic                                first_of_volume,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [frbf_pkg::DATA_W-1:0]  result_re,
  output logic signed [frbf_pkg::DATA_W-1:0]  result_im,
  output logic [frbf_pkg::GAIN_W-1:0]         mask_value,
  output logic                                last_of_volume,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [frbf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                         cfg_data
);
  import frbf_pkg::*;

`include "fourier_radial_band_filter_assert.svh"

  cfg_t cfg;
  job_t f_job, q_job;
  logic f_enq, q_empty, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode      <= '0;
      cfg.size_x    <= DIM_W'(256);
      cfg.size_y    <= DIM_W'(256);
      cfg.size_z    <= DIM_W'(1);
      cfg.hp_cutoff <= '0;
      cfg.hp_width  <= '0;
      cfg.lp_cutoff <= 16'd16384;
      cfg.lp_width  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:      cfg.mode      <= cfg_data[MODE_W-1:0];
        CFG_SIZE_X:    cfg.size_x    <= cfg_data[DIM_W-1:0];
        CFG_SIZE_Y:    cfg.size_y    <= cfg_data[DIM_W-1:0];
        CFG_SIZE_Z:    cfg.size_z    <= cfg_data[DIM_W-1:0];
        CFG_HP_CUTOFF: cfg.hp_cutoff <= cfg_data;
        CFG_HP_WIDTH:  cfg.hp_width  <= cfg_data;
        CFG_LP_CUTOFF: cfg.lp_cutoff <= cfg_data;
        CFG_LP_WIDTH:  cfg.lp_width  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  frbf_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .first_of_volume (first_of_volume),
    .sample_re       (sample_re),
    .sample_im       (sample_im),
    .cfg             (cfg),
    .full            (full),
    .enq             (f_enq),
    .job             (f_job)
  );

  frbf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .enq     (f_enq),
    .wr_data (f_job),
    .full    (full),
    .deq     (q_pop),
    .rd_data (q_job),
    .empty   (q_empty)
  );

  frbf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_empty        (q_empty),
    .q_data         (q_job),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .result_re      (result_re),
    .result_im      (result_im),
    .mask_value     (mask_value),
    .last_of_volume (last_of_volume)
  );

  `FRBF_ASSERT_NEVER(a_mask_range, !empty && mask_value > 16'd32768, "mask above unity")
  `FRBF_ASSERT_IMPL(a_mask_only_zero, !empty && cfg.mode >= MODE_MASK_ONLY, result_re == '0 && result_im == '0, "data in mask-only mode")
  `FRBF_ASSERT_IMPL(a_full_has_data, full, !q_empty, "queue full yet empty")

endmodule
`default_nettype wire

[hw/rtl/frbf_front.sv]
`default_nettype none
module frbf_front (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       push,
  input  logic                                       first_of_volume,
  input  logic signed [frbf_pkg::DATA_W-1:0]         sample_re,
  input  logic signed [frbf_pkg::DATA_W-1:0]         sample_im,
  input  frbf_pkg::cfg_t                             cfg,
  input  logic                                       full,
  output logic                                       enq,
  output frbf_pkg::job_t                             job
);
  import frbf_pkg::*;

  logic [POS_W-1:0] pos_x, pos_y, pos_z;
  logic [POS_W-1:0] pos_x_next, pos_y_next, pos_z_next;
  logic [POS_W-1:0] px, py, pz;
  logic [DIM_W-1:0] sx, sy, sz, hx;
  logic             lx, ly, lz;

  assign enq = push && !full;
  assign sx  = eff_size(cfg.size_x);
  assign sy  = eff_size(cfg.size_y);
  assign sz  = eff_size(cfg.size_z);
  assign hx  = {1'b0, sx[DIM_W-1:1]} + DIM_W'(1);
  assign px  = first_of_volume ? '0 : pos_x;
  assign py  = first_of_volume ? '0 : pos_y;
  assign pz  = first_of_volume ? '0 : pos_z;
  assign lx  = ({1'b0, px} + DIM_W'(1)) >= hx;
  assign ly  = ({1'b0, py} + DIM_W'(1)) >= sy;
  assign lz  = ({1'b0, pz} + DIM_W'(1)) >= sz;

  always_comb begin
    job.ax   = px;
    job.ay   = fold_index(py, sy);
    job.az   = fold_index(pz, sz);
    job.dx   = sx;
    job.dy   = sy;
    job.dz   = sz;
    job.re   = sample_re;
    job.im   = sample_im;
    job.last = lx && ly && lz;
  end

  always_comb begin
    pos_x_next = px + POS_W'(1);
    pos_y_next = py;
    pos_z_next = pz;
    if (lx) begin
      pos_x_next = '0;
      pos_y_next = py + POS_W'(1);
      if (ly) begin
        pos_y_next = '0;
        pos_z_next = lz ? '0 : pz + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (enq) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      pos_z <= pos_z_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/frbf_queue.sv]
`default_nettype none
module frbf_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           enq,
  input  frbf_pkg::job_t wr_data,
  output logic           full,
  input  logic           deq,
  output frbf_pkg::job_t rd_data,
  output logic           empty
);
  import frbf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (enq && !deq) begin
        count <= count + CW'(1);
      end else if (deq && !enq) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/frbf_div.sv]
`default_nettype none
module frbf_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [frbf_pkg::DIV_NUM_W-1:0]  num,
  input  logic [frbf_pkg::DIV_DEN_W-1:0]  den,
  output logic                            done,
  output logic [frbf_pkg::DIV_NUM_W-1:0]  quo
);
  import frbf_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dvs;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 take;

  assign rem_sh = {rem, quo[DIV_NUM_W-1]};
  assign take   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      dvs <= den;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DIV_NUM_W-2:0], take};
      rem <= take ? DIV_DEN_W'(rem_sh - {1'b0, dvs}) : rem_sh[DIV_DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/frbf_back.sv]
`default_nettype none
module frbf_back (
  input  logic                                clk,
  input  logic                                rst,
  input  frbf_pkg::cfg_t                      cfg,
  input  logic                                q_empty,
  input  frbf_pkg::job_t                      q_data,
  output logic                                q_pop,
  input  logic                                pop,
  output logic                                empty,
  output logic signed [frbf_pkg::DATA_W-1:0]  result_re,
  output logic signed [frbf_pkg::DATA_W-1:0]  result_im,
  output logic [frbf_pkg::GAIN_W-1:0]         mask_value,
  output logic                                last_of_volume
);
  import frbf_pkg::*;

  state_t st, st_next;
  job_t   job;
  kind_t  kind;
  logic   mask_only;

  logic                 dv_start, dv_done;
  logic [DIV_NUM_W-1:0] dv_num, dv_quo;
  logic [DIV_DEN_W-1:0] dv_den;

  logic [1:0]          term;
  logic [POS_W-1:0]    t_a;
  logic [DIM_W-1:0]    t_d;
  logic [17:0]         t_a2;
  logic [18:0]         t_d2;
  logic [SUM_W-1:0]    sum, sum_new;

  logic [SUM_W-1:0]    sq_src;
  logic [SQ_REM_W-1:0] sq_rem;
  logic [ROOT_W-1:0]   sq_root;
  logic [SQ_CNT_W-1:0] sq_cnt;
  logic [SQ_REM_W+1:0] sq_sh, sq_trial;
  logic                sq_take;
  logic [F_W-1:0]      f;

  logic                edge_lp;
  logic                lp_one, lp_zero, hp_one, hp_zero;
  logic                e_one, e_zero;
  logic [15:0]         e_d, e_w;

  logic [16:0]         h_p, h_v, h_vq;
  logic [17:0]         h_2p;
  logic                h_lower, h_lower_q;
  logic [16:0]         v2;
  logic [15:0]         t1;
  logic [16:0]         t2;
  logic [34:0]         v2_full;
  logic [30:0]         t1_full;
  logic [33:0]         t2_full;
  logic [34:0]         s_full;
  logic [16:0]         s_clip;
  logic [17:0]         twice;
  logic [18:0]         gain_full;

  logic [GAIN_W-1:0]   hp_gain, lp_gain, mask;
  logic [32:0]         bp_full;
  logic signed [48:0]  sc_full;
  logic signed [DATA_W-1:0] sc_src, res_re, res_im;

  logic out_valid;

  frbf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  assign kind      = filter_kind(cfg.mode);
  assign mask_only = cfg.mode >= MODE_MASK_ONLY;
  assign empty     = !out_valid;

  always_comb begin
    case (term)
      2'd0:    begin t_a = job.ax; t_d = job.dx; end
      2'd1:    begin t_a = job.ay; t_d = job.dy; end
      default: begin t_a = job.az; t_d = job.dz; end
    endcase
  end
  assign t_a2    = 18'(t_a) * 18'(t_a);
  assign t_d2    = 19'(t_d) * 19'(t_d);
  assign sum_new = sum + dv_quo;

  assign sq_sh    = {sq_rem, sq_src[SUM_W-1:SUM_W-2]};
  assign sq_trial = {1'b0, sq_root, 2'b01};
  assign sq_take  = sq_sh >= sq_trial;

  assign lp_one  = f <= F_W'(cfg.lp_cutoff);
  assign lp_zero = f >= F_W'({1'b0, cfg.lp_cutoff} + {1'b0, cfg.lp_width});
  assign hp_one  = f >= F_W'(cfg.hp_cutoff);
  assign hp_zero = ({1'b0, f} + (F_W + 1)'(cfg.hp_width)) <= (F_W + 1)'(cfg.hp_cutoff);

  always_comb begin
    if (edge_lp) begin
      e_one  = lp_one;
      e_zero = lp_zero;
      e_d    = f[15:0] - cfg.lp_cutoff;
      e_w    = cfg.lp_width;
    end else begin
      e_one  = hp_one;
      e_zero = hp_zero;
      e_d    = cfg.hp_cutoff - f[15:0];
      e_w    = cfg.hp_width;
    end
  end

  assign h_p     = (dv_quo > DIV_NUM_W'(65536)) ? 17'd65536 : dv_quo[16:0];
  assign h_2p    = {h_p, 1'b0};
  assign h_lower = h_2p < 18'd65536;
  assign h_v     = h_lower ? 17'(18'd65536 - h_2p) : 17'(h_2p - 18'd65536);

  assign v2_full   = 35'(h_vq * h_vq) + 35'd32768;
  assign t1_full   = 31'(v2 * COEF_C) + 31'd32768;
  assign t2_full   = 34'(v2 * t1) + 34'd32768;
  assign s_full    = 35'(h_vq * t2) + 35'd32768;
  assign s_clip    = (s_full[34:16] > 19'd65536) ? 17'd65536 : s_full[32:16];
  assign twice     = h_lower_q ? 18'd65536 + 18'(s_clip) : 18'd65536 - 18'(s_clip);
  assign gain_full = 19'(twice) + 19'd2;

  assign bp_full = 33'(hp_gain * lp_gain) + 33'd16384;
  assign sc_src  = (st == ST_SCALE_RE) ? job.re : job.im;
  assign sc_full = 49'(sc_src * $signed({1'b0, mask})) + 49'sd16384;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next  = st;
    q_pop    = 1'b0;
    dv_start = 1'b0;
    dv_num   = {2'b0, t_a2, 30'b0} + DIV_NUM_W'(t_d2);
    dv_den   = {t_d2, 1'b0};
    case (st)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          st_next = ST_TERM_GO;
        end
      end
      ST_TERM_GO: begin
        dv_num   = {1'b0, t_a2, 31'b0} + DIV_NUM_W'(t_d2);
        dv_start = 1'b1;
        st_next  = ST_TERM_WAIT;
      end
      ST_TERM_WAIT: begin
        if (dv_done) begin
          st_next = (term == 2'd2) ? ST_SQRT : ST_TERM_GO;
        end
      end
      ST_SQRT: begin
        if (sq_cnt == SQ_CNT_W'(1)) begin
          st_next = ST_SQRT_FIX;
        end
      end
      ST_SQRT_FIX: begin
        st_next = ST_EDGE;
      end
      ST_EDGE: begin
        dv_num = DIV_NUM_W'({e_d, 17'b0}) + DIV_NUM_W'(e_w);
        dv_den = DIV_DEN_W'({e_w, 1'b0});
        if (!e_one && !e_zero) begin
          dv_start = 1'b1;
          st_next  = ST_HANN_WAIT;
        end else if (!edge_lp && kind == KIND_BP) begin
          st_next = ST_EDGE;
        end else begin
          st_next = ST_MASK;
        end
      end
      ST_HANN_WAIT: begin
        if (dv_done) begin
          st_next = ST_HANN_V2;
        end
      end
      ST_HANN_V2: st_next = ST_HANN_T1;
      ST_HANN_T1: st_next = ST_HANN_T2;
      ST_HANN_T2: st_next = ST_HANN_S;
      ST_HANN_S: begin
        st_next = (!edge_lp && kind == KIND_BP) ? ST_EDGE : ST_MASK;
      end
      ST_MASK:     st_next = ST_SCALE_RE;
      ST_SCALE_RE: st_next = ST_SCALE_IM;
      ST_SCALE_IM: st_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || pop) begin
          st_next = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st)
      ST_IDLE: begin
        job  <= q_data;
        term <= 2'd0;
        sum  <= '0;
      end
      ST_TERM_WAIT: begin
        if (dv_done) begin
          sum    <= sum_new;
          term   <= term + 2'd1;
          sq_src <= sum_new;
          sq_rem <= '0;
          sq_root <= '0;
          sq_cnt <= SQ_CNT_W'(ROOT_W);
        end
      end
      ST_SQRT: begin
        sq_src  <= {sq_src[SUM_W-3:0], 2'b00};
        sq_rem  <= sq_take ? SQ_REM_W'(sq_sh - sq_trial) : sq_sh[SQ_REM_W-1:0];
        sq_root <= {sq_root[ROOT_W-2:0], sq_take};
        sq_cnt  <= sq_cnt - SQ_CNT_W'(1);
      end
      ST_SQRT_FIX: begin
        f       <= F_W'(sq_root) + F_W'(sq_rem > SQ_REM_W'(sq_root));
        edge_lp <= kind == KIND_LP;
      end
      ST_EDGE: begin
        if (e_one || e_zero) begin
          if (edge_lp) begin
            lp_gain <= e_one ? ONE_Q[GAIN_W-1:0] : '0;
          end else begin
            hp_gain <= e_one ? ONE_Q[GAIN_W-1:0] : '0;
          end
          if (!edge_lp && kind == KIND_BP) begin
            edge_lp <= 1'b1;
          end
        end
      end
      ST_HANN_WAIT: begin
        if (dv_done) begin
          h_vq      <= h_v;
          h_lower_q <= h_lower;
        end
      end
      ST_HANN_V2: v2 <= v2_full[32:16];
      ST_HANN_T1: t1 <= COEF_B - 16'(t1_full[30:16]);
      ST_HANN_T2: t2 <= COEF_A - 17'(t2_full[33:16]);
      ST_HANN_S: begin
        if (edge_lp) begin
          lp_gain <= gain_full[17:2];
        end else begin
          hp_gain <= gain_full[17:2];
        end
        if (!edge_lp && kind == KIND_BP) begin
          edge_lp <= 1'b1;
        end
      end
      ST_MASK: begin
        case (kind)
          KIND_LP: mask <= lp_gain;
          KIND_HP: mask <= hp_gain;
          default: mask <= bp_full[30:15];
        endcase
      end
      ST_SCALE_RE: res_re <= mask_only ? '0 : sc_full[46:15];
      ST_SCALE_IM: res_im <= mask_only ? '0 : sc_full[46:15];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (st == ST_DONE && (!out_valid || pop)) begin
      result_re      <= res_re;
      result_im      <= res_im;
      mask_value     <= mask;
      last_of_volume <= job.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == ST_DONE && (!out_valid || pop)) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[bench/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import frbf_pkg::*;

  localparam logic [MODE_W-1:0] MODE_LP = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HP = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BP_MASK = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SIX = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SEVEN = 3'd7;
  localparam int DRAIN_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam int RANDOM_ITEMS = 1200;

  typedef struct {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic [GAIN_W-1:0] mask;
    logic last;
  } filtered_coeff_t;

  typedef struct {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic first;
    logic known;
    filtered_coeff_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic signed [DATA_W-1:0] sample_re = '0;
  logic signed [DATA_W-1:0] sample_im = '0;
  logic first_of_volume = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [DATA_W-1:0] result_re;
  logic signed [DATA_W-1:0] result_im;
  logic [GAIN_W-1:0] mask_value;
  logic last_of_volume;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic row_known = 1'b0;
  filtered_coeff_t row_want;

  filtered_coeff_t expected_q[$];
  int unsigned errors = 0;
  longint cycles = 0;
  bit quiet = 1'b0;

  logic [15:0] regs [8];
  logic [POS_W-1:0] px, py, pz;

  fourier_radial_band_filter u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .sample_re(sample_re), .sample_im(sample_im), .first_of_volume(first_of_volume),
    .empty(empty), .pop(pop), .result_re(result_re), .result_im(result_im),
    .mask_value(mask_value), .last_of_volume(last_of_volume),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic longint unsigned clamp_dim(input logic [15:0] s);
    if (s == 0) return 1;
    if (s > MAX_DIM) return MAX_DIM;
    return s;
  endfunction

  function automatic longint unsigned radial_term(input longint unsigned idx,
                                                  input longint unsigned dim,
                                                  input bit fold);
    longint unsigned a, num, den;
    a = idx;
    if (fold && idx >= dim / 2 + 1) a = (idx >= dim) ? idx - dim : dim - idx;
    num = (a * a) << 30;
    den = dim * dim;
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic longint unsigned root_nearest(input longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (s > r) r++;
    return r;
  endfunction

  function automatic longint unsigned hann_edge(input longint unsigned d,
                                                input longint unsigned w);
    longint unsigned p, v, v2, t1, t2, s, twice;
    bit lower;
    p = ((d << 17) + w) / (2 * w);
    if (p > 65536) p = 65536;
    lower = (2 * p) < 65536;
    v = lower ? 65536 - 2 * p : 2 * p - 65536;
    v2 = (v * v + 32768) >> 16;
    t1 = 42047 - ((v2 * 4639 + 32768) >> 16);
    t2 = 102944 - ((v2 * t1 + 32768) >> 16);
    s = (v * t2 + 32768) >> 16;
    if (s > 65536) s = 65536;
    twice = lower ? 65536 + s : 65536 - s;
    return ((twice << 15) + 65536) >> 17;
  endfunction

  function automatic longint unsigned lowpass_gain(input longint unsigned f);
    longint unsigned c, w;
    c = regs[CFG_LP_CUTOFF];
    w = regs[CFG_LP_WIDTH];
    if (f <= c) return 32768;
    if (f >= c + w) return 0;
    return hann_edge(f - c, w);
  endfunction

  function automatic longint unsigned highpass_gain(input longint unsigned f);
    longint c, w;
    c = regs[CFG_HP_CUTOFF];
    w = regs[CFG_HP_WIDTH];
    if (longint'(f) >= c) return 32768;
    if (longint'(f) <= c - w) return 0;
    return hann_edge(c - f, w);
  endfunction

  function automatic logic signed [DATA_W-1:0] apply_gain(input logic signed [DATA_W-1:0] x,
                                                          input longint unsigned g);
    longint q, r;
    q = longint'(x) * longint'(g) + 16384;
    if (q >= 0) r = q / 32768;
    else r = -((-q + 32767) / 32768);
    return r[DATA_W-1:0];
  endfunction

  function automatic filtered_coeff_t filter_coeff(input logic signed [DATA_W-1:0] re,
                                                   input logic signed [DATA_W-1:0] im,
                                                   input logic first);
    filtered_coeff_t o;
    logic [MODE_W-1:0] mode;
    longint unsigned sx, sy, sz, f, g;
    bit lx, ly, lz;
    mode = (regs[CFG_MODE] > MODE_BP_MASK) ? MODE_BP_MASK : regs[CFG_MODE][MODE_W-1:0];
    sx = clamp_dim(regs[CFG_SIZE_X]);
    sy = clamp_dim(regs[CFG_SIZE_Y]);
    sz = clamp_dim(regs[CFG_SIZE_Z]);
    if (first) begin
      px = '0;
      py = '0;
      pz = '0;
    end
    f = root_nearest(radial_term(px, sx, 0) + radial_term(py, sy, 1) + radial_term(pz, sz, 1));
    case (mode % 3)
      MODE_LP: g = lowpass_gain(f);
      MODE_HP: g = highpass_gain(f);
      MODE_BP: g = (highpass_gain(f) * lowpass_gain(f) + 16384) >> 15;
      default: g = 0;
    endcase
    lx = longint'(px) + 1 >= sx / 2 + 1;
    ly = longint'(py) + 1 >= sy;
    lz = longint'(pz) + 1 >= sz;
    o.last = lx && ly && lz;
    if (!lx) begin
      px = px + 1'b1;
    end else begin
      px = '0;
      if (!ly) begin
        py = py + 1'b1;
      end else begin
        py = '0;
        pz = lz ? '0 : pz + 1'b1;
      end
    end
    o.mask = g[GAIN_W-1:0];
    o.re = (mode >= MODE_MASK_ONLY) ? '0 : apply_gain(re, g);
    o.im = (mode >= MODE_MASK_ONLY) ? '0 : apply_gain(im, g);
    return o;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    filtered_coeff_t e;
    filtered_coeff_t p;
    if (!rst && push && !full) begin
      p = filter_coeff(sample_re, sample_im, first_of_volume);
      expected_q.push_back(row_known ? row_want : p);
    end
    if (!rst && pop && !empty) begin
      if (expected_q.size() == 0) begin
        $error("result_re: no request pending, got %0d", result_re);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (result_re !== e.re) begin
          $error("result_re: expected %0d actual %0d", e.re, result_re);
          errors++;
        end
        if (result_im !== e.im) begin
          $error("result_im: expected %0d actual %0d", e.im, result_im);
          errors++;
        end
        if (mask_value !== e.mask) begin
          $error("mask_value: expected %0d actual %0d", e.mask, mask_value);
          errors++;
        end
        if (last_of_volume !== e.last) begin
          $error("last_of_volume: expected %0d actual %0d", e.last, last_of_volume);
          errors++;
        end
      end
    end
  end

  function automatic int draw_gap();
    if (quiet) return 0;
    return $urandom_range(0, 17);
  endfunction

  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = draw_gap();
      if (n > 0) begin
        pop <= 1'b0;
        repeat (n) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    regs[idx] = (idx == CFG_MODE) ? (value & 16'h7) :
                (idx <= CFG_SIZE_Z) ? (value & 16'h3ff) : value;
  endtask

  task automatic send_coeff(input logic signed [DATA_W-1:0] re,
                            input logic signed [DATA_W-1:0] im,
                            input logic first, input logic known,
                            input filtered_coeff_t want);
    int n;
    n = draw_gap();
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
    push <= 1'b1;
    sample_re <= re;
    sample_im <= im;
    first_of_volume <= first;
    row_known <= known;
    row_want <= want;
    do @(posedge clk); while (full);
  endtask

  task automatic drain();
    push <= 1'b0;
    row_known <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_all(input logic [15:0] v[8]);
    for (int i = 0; i < 8; i++) write_reg(i[CFG_IDX_W-1:0], v[i]);
    cfg_valid <= 1'b0;
  endtask

  stim_row_t stim_table[$];
  filtered_coeff_t none;

  function automatic logic [15:0] pick_width();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom_range(1, 64));
      default: return 16'($urandom_range(1, 16000));
    endcase
  endfunction

  function automatic logic [15:0] pick_size(input bit big);
    if (big) begin
      case ($urandom_range(0, 3))
        0: return 16'd0;
        1: return 16'd1023;
        2: return 16'd512;
        default: return 16'($urandom_range(1, 1023));
      endcase
    end
    return 16'($urandom_range(1, 9));
  endfunction

  initial begin
    logic [15:0] v[8];
    int sent, len, cnt;
    bit big;
    none = '{re: '0, im: '0, mask: '0, last: 1'b0};
    regs = '{16'd0, 16'd256, 16'd256, 16'd1, 16'd0, 16'd0, 16'd16384, 16'd0};
    px = '0;
    py = '0;
    pz = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    stim_table = '{
      '{32'sh7fffffff, -32'sh80000000, 1'b1, 1'b1,
        '{32'sh7fffffff, -32'sh80000000, 16'd32768, 1'b0}},
      '{-32'sh80000000, 32'sh7fffffff, 1'b0, 1'b1,
        '{-32'sh80000000, 32'sh7fffffff, 16'd32768, 1'b0}},
      '{32'sd0, -32'sd1, 1'b0, 1'b1, '{32'sd0, -32'sd1, 16'd32768, 1'b0}},
      '{32'sd12345, -32'sd999, 1'b0, 1'b0, none}
    };
    foreach (stim_table[i])
      send_coeff(stim_table[i].re, stim_table[i].im, stim_table[i].first,
                 stim_table[i].known, stim_table[i].want);
    drain();

    // walk every mode, including the aliases of bandpass mask-only
    for (int m = 0; m < 8; m++) begin
      v = '{16'(m), 16'd4, 16'd3, 16'd2, 16'd6000, 16'd9000, 16'd14000, 16'd9000};
      if (m == MODE_SIX) v[CFG_SIZE_Z] = 16'd0;
      if (m == MODE_SEVEN) v[CFG_SIZE_X] = 16'd1023;
      write_all(v);
      send_coeff(32'sh7fffffff, -32'sh80000000, 1'b1, 1'b0, none);
      send_coeff(32'($urandom), 32'($urandom), 1'b0, 1'b0, none);
      drain();
    end

    sent = 0;
    cnt = 0;
    while (sent < RANDOM_ITEMS) begin
      big = ($urandom_range(0, 7) == 0);
      quiet = ($urandom_range(0, 3) == 0);
      v[CFG_MODE] = 16'($urandom_range(0, 7));
      v[CFG_SIZE_X] = pick_size(big);
      v[CFG_SIZE_Y] = pick_size(big);
      v[CFG_SIZE_Z] = ($urandom_range(0, 2) == 0) ? 16'd1 : pick_size(big);
      v[CFG_HP_CUTOFF] = ($urandom_range(0, 9) == 0) ? 16'hffff : 16'($urandom_range(0, 30000));
      v[CFG_HP_WIDTH] = pick_width();
      v[CFG_LP_CUTOFF] = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(0, 30000));
      v[CFG_LP_WIDTH] = pick_width();
      write_all(v);
      len = big ? $urandom_range(5, 20) : $urandom_range(40, 120);
      for (int k = 0; k < len; k++) begin
        send_coeff(32'($urandom), 32'($urandom),
                   (k == 0) || ($urandom_range(0, 39) == 0), 1'b0, none);
        sent++;
      end
      cnt++;
      // resize the volume mid-stream on every fourth phase
      if (cnt % 4 == 0) begin
        drain();
        write_reg(CFG_SIZE_Y, 16'($urandom_range(1, 3)));
        write_reg(CFG_SIZE_X, 16'($urandom_range(1, 3)));
        cfg_valid <= 1'b0;
        for (int k = 0; k < 12; k++) begin
          send_coeff(32'($urandom), 32'($urandom), 1'b0, 1'b0, none);
          sent++;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
